// ===== rtl/mandelbrot_escape_time_macros.svh =====
// Assertion macros for the escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escape-time check failed");

// Next-cycle implication, disabled during reset
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escape-time check failed");

`endif

// ===== rtl/mbe_pkg.sv =====
// Shared types and constants of the escape-time block
`default_nettype none

package mbe_pkg;

   localparam int C_W       = 32;
   localparam int MAG_W     = 34;
   localparam int MAX_IT_W  = 16;
   localparam int CSR_W     = 34;

   localparam logic [MAX_IT_W-1:0] MAX_IT_RESET = 16'd256;
   localparam logic [MAG_W-1:0]    MAG_MAX      = 34'h3_FFFF_FFFF;

   typedef enum logic {
      CSR_MAX_ITERATIONS = 1'b0,
      CSR_BAILOUT_SQ     = 1'b1
   } mbe_csr_type;

   typedef enum logic [1:0] {
      PART_LL = 2'd0,
      PART_LH = 2'd1,
      PART_HL = 2'd2,
      PART_HH = 2'd3
   } mbe_part_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_LOAD,
      ST_MUL,
      ST_DRAIN,
      ST_FINISH
   } mbe_state_type;

   typedef struct packed {
      logic         init;
      logic         step;
      logic         done;
      logic         load;
      logic         mul_en;
      mbe_part_type sel;
      logic         finish;
   } mbe_cmd_type;

   typedef struct packed {
      logic cont;
   } mbe_status_type;

endpackage

`default_nettype wire

// ===== rtl/mbe_ctrl.sv =====
// Sequencer of the escape-time block
`default_nettype none

module mbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mbe_pkg::mbe_status_type status,
   output mbe_pkg::mbe_cmd_type    cmd
);
   import mbe_pkg::*;

   mbe_state_type state_ff, state_in;
   mbe_part_type  sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= PART_LL;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      cmd        = '0;
      cmd.sel    = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.init = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.cont) begin
               cmd.step = 1'b1;
               state_in = ST_LOAD;
            end else begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            sel_in   = PART_LL;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            sel_in     = mbe_part_type'(sel_ff + 2'd1);
            if (sel_ff == PART_HH) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_STEP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/mbe_mul.sv =====
// Split multiplier lane: four half-width partial products accumulated over cycles
`default_nettype none

module mbe_mul #(
   parameter int OP_W = 37
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          mul_en,
   input  mbe_pkg::mbe_part_type         sel,
   input  logic [OP_W-1:0]               a,
   input  logic [OP_W-1:0]               b,
   output logic [4*((OP_W+1)/2)-1:0]     acc
);
   import mbe_pkg::*;

   localparam int HALF_W = (OP_W + 1) / 2;
   localparam int PROD_W = 2 * HALF_W;
   localparam int ACC_W  = 4 * HALF_W;

   logic [PROD_W-1:0] a_ff, b_ff;
   logic [HALF_W-1:0] part_a, part_b;
   logic [PROD_W-1:0] prod_ff;
   mbe_part_type      psel_ff;
   logic              pvalid_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in, addend;

   assign part_a = (sel == PART_HL || sel == PART_HH) ? a_ff[PROD_W-1:HALF_W]
                                                      : a_ff[HALF_W-1:0];
   assign part_b = (sel == PART_LH || sel == PART_HH) ? b_ff[PROD_W-1:HALF_W]
                                                      : b_ff[HALF_W-1:0];

   always_comb begin
      unique case (psel_ff)
         PART_LL: addend = ACC_W'(prod_ff);
         PART_LH,
         PART_HL: addend = ACC_W'(prod_ff) << HALF_W;
         PART_HH: addend = ACC_W'(prod_ff) << PROD_W;
      endcase
      acc_in = pvalid_ff ? acc_ff + addend : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff      <= PROD_W'(a);
         b_ff      <= PROD_W'(b);
         acc_ff    <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         pvalid_ff <= mul_en;
      end
      prod_ff <= PROD_W'(part_a) * PROD_W'(part_b);
      psel_ff <= sel;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/mbe_datapath.sv =====
// Datapath: point and z registers, three multiplier lanes, settings and result registers
`default_nettype none

module mbe_datapath #(
   parameter int FRAC_BITS  = 28,
   parameter int ITER_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mbe_pkg::mbe_cmd_type         cmd,
   output mbe_pkg::mbe_status_type      status,
   input  logic signed [31:0]          req_c_real,
   input  logic signed [31:0]          req_c_imag,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [33:0]                 csr_wdata,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_iterations,
   output logic                        rsp_escaped,
   output logic [33:0]                 rsp_magnitude_sq
);
   import mbe_pkg::*;

   localparam int Z_W    = FRAC_BITS + 8;
   localparam int OP_W   = Z_W + 1;
   localparam int HALF_W = (OP_W + 1) / 2;
   localparam int ACC_W  = 4 * HALF_W;
   localparam int RND_W  = ACC_W + 1;
   localparam int R_W    = RND_W - FRAC_BITS;
   localparam int SUM_W  = (Z_W + 2 > 33) ? Z_W + 2 : 33;
   localparam int MS_W   = (Z_W + 1 > MAG_W + 1) ? Z_W + 1 : MAG_W + 1;
   localparam int CNT_W  = (ITER_WIDTH > MAX_IT_W) ? ITER_WIDTH : MAX_IT_W;

   localparam logic [63:0]        BAIL_WIDE  = 64'd4 << FRAC_BITS;
   localparam logic [MAG_W-1:0]   BAIL_RESET = (BAIL_WIDE > 64'(MAG_MAX)) ? MAG_MAX
                                                : BAIL_WIDE[MAG_W-1:0];
   localparam logic signed [SUM_W-1:0] Z_POS = {{(SUM_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] Z_NEG = {{(SUM_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};
   localparam logic [Z_W-1:0]     Z_POS_Z    = {1'b0, {(Z_W-1){1'b1}}};
   localparam logic [R_W-1:0]     SQ_MAX_R   = {{(R_W-Z_W){1'b0}}, {Z_W{1'b1}}};
   localparam logic [R_W-1:0]     P_CAP_R    = {{(R_W-Z_W){1'b0}}, 1'b1, {(Z_W-1){1'b0}}};
   localparam logic [RND_W-1:0]   RND_HALF   = RND_W'(1) << (FRAC_BITS - 1);
   localparam logic [CNT_W-1:0]   CNT_MASK   = CNT_W'({ITER_WIDTH{1'b1}});

   function automatic logic [R_W-1:0] round_shift(input logic [ACC_W-1:0] v);
      logic [RND_W-1:0] t;
      t = RND_W'(v) + RND_HALF;
      return t[RND_W-1:FRAC_BITS];
   endfunction

   function automatic logic [Z_W-1:0] clamp_z(input logic signed [SUM_W-1:0] v);
      logic [Z_W-1:0] r;
      if (v > Z_POS) begin
         r = Z_POS[Z_W-1:0];
      end else if (v < Z_NEG) begin
         r = Z_NEG[Z_W-1:0];
      end else begin
         r = v[Z_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [Z_W-1:0] sat_sq(input logic [R_W-1:0] v);
      return (v > SQ_MAX_R) ? SQ_MAX_R[Z_W-1:0] : v[Z_W-1:0];
   endfunction

   // settings
   logic [MAX_IT_W-1:0]  maxit_ff;
   logic [MAG_W-1:0]     bail_ff;

   // point and iteration state
   logic signed [31:0]   cr_ff, ci_ff;
   logic signed [Z_W-1:0] zr_ff, zi_ff, cross_ff;
   logic [Z_W-1:0]       sqr_ff, sqi_ff;
   logic [ITER_WIDTH-1:0] count_ff, limit_ff;

   // result
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_iter_ff;
   logic                 rsp_esc_ff;
   logic [MAG_W-1:0]     rsp_mag_ff;

   logic [Z_W-1:0]       mag_r, mag_i;
   logic [OP_W-1:0]      op_x_a, op_x_b, op_r, op_i;
   logic [ACC_W-1:0]     acc_x, acc_r, acc_i;
   logic signed [SUM_W-1:0] zi_sum, zr_sum;
   logic [R_W-1:0]       r_x;
   logic [Z_W-1:0]       p_cap;
   logic [Z_W-1:0]       cross_in;
   logic                 neg;
   logic [MS_W-1:0]      mag_sum;
   logic [MAG_W-1:0]     mag_sat;
   logic [CNT_W-1:0]     maxit_ext, limit_ext, count_ext;
   logic                 below_limit;

   assign mag_r  = zr_ff[Z_W-1] ? (~zr_ff) + Z_W'(1) : zr_ff;
   assign mag_i  = zi_ff[Z_W-1] ? (~zi_ff) + Z_W'(1) : zi_ff;
   assign op_x_a = {mag_r, 1'b0};
   assign op_x_b = {1'b0, mag_i};
   assign op_r   = {1'b0, mag_r};
   assign op_i   = {1'b0, mag_i};

   mbe_mul #(.OP_W(OP_W)) u_mul_cross (
      .clock  (clock),
      .load   (cmd.load),
      .mul_en (cmd.mul_en),
      .sel    (cmd.sel),
      .a      (op_x_a),
      .b      (op_x_b),
      .acc    (acc_x)
   );

   mbe_mul #(.OP_W(OP_W)) u_mul_real (
      .clock  (clock),
      .load   (cmd.load),
      .mul_en (cmd.mul_en),
      .sel    (cmd.sel),
      .a      (op_r),
      .b      (op_r),
      .acc    (acc_r)
   );

   mbe_mul #(.OP_W(OP_W)) u_mul_imag (
      .clock  (clock),
      .load   (cmd.load),
      .mul_en (cmd.mul_en),
      .sel    (cmd.sel),
      .a      (op_i),
      .b      (op_i),
      .acc    (acc_i)
   );

   always_comb begin
      zi_sum = SUM_W'(cross_ff) + SUM_W'(ci_ff);
      zr_sum = $signed(SUM_W'(sqr_ff)) - $signed(SUM_W'(sqi_ff)) + SUM_W'(cr_ff);

      r_x   = round_shift(acc_x);
      p_cap = (r_x > P_CAP_R) ? P_CAP_R[Z_W-1:0] : r_x[Z_W-1:0];
      neg   = zr_ff[Z_W-1] ^ zi_ff[Z_W-1];
      if (neg) begin
         cross_in = (~p_cap) + Z_W'(1);
      end else if (p_cap[Z_W-1]) begin
         cross_in = Z_POS_Z;
      end else begin
         cross_in = p_cap;
      end

      mag_sum = MS_W'(sqr_ff) + MS_W'(sqi_ff);
      mag_sat = (mag_sum > MS_W'(MAG_MAX)) ? MAG_MAX : mag_sum[MAG_W-1:0];

      maxit_ext   = CNT_W'(maxit_ff);
      limit_ext   = (maxit_ext < CNT_MASK) ? maxit_ext : CNT_MASK;
      count_ext   = CNT_W'(count_ff);
      below_limit = (count_ff < limit_ff);

      status.cont = (mag_sum <= MS_W'(bail_ff)) && below_limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxit_ff     <= MAX_IT_RESET;
         bail_ff      <= BAIL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.done;
         if (csr_we) begin
            unique case (mbe_csr_type'(csr_index))
               CSR_MAX_ITERATIONS: maxit_ff <= csr_wdata[MAX_IT_W-1:0];
               CSR_BAILOUT_SQ:     bail_ff  <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         cr_ff    <= req_c_real;
         ci_ff    <= req_c_imag;
         zr_ff    <= '0;
         zi_ff    <= '0;
         cross_ff <= '0;
         sqr_ff   <= '0;
         sqi_ff   <= '0;
         count_ff <= '0;
         limit_ff <= limit_ext[ITER_WIDTH-1:0];
      end
      if (cmd.step) begin
         zi_ff    <= clamp_z(zi_sum);
         zr_ff    <= clamp_z(zr_sum);
         count_ff <= count_ff + ITER_WIDTH'(1);
      end
      if (cmd.finish) begin
         cross_ff <= cross_in;
         sqr_ff   <= sat_sq(round_shift(acc_r));
         sqi_ff   <= sat_sq(round_shift(acc_i));
      end
      if (cmd.done) begin
         rsp_iter_ff <= count_ext[15:0];
         rsp_esc_ff  <= below_limit;
         rsp_mag_ff  <= mag_sat;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_iterations   = rsp_iter_ff;
   assign rsp_escaped      = rsp_esc_ff;
   assign rsp_magnitude_sq = rsp_mag_ff;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time.sv =====
// Escape-time engine: top level joining sequencer and datapath
// A point's result strobes once its iterations end, registered from the sequencer's done command.
// Each iteration runs these steps in order: test and z update, operand load, four partial products
// on three half-width multiplier lanes, accumulate, round and saturate.
// A new point is accepted in the strobe cycle; the receiver cannot stall.
// Reset clears the sequencer and restores the iteration limit (256) and bailout (4.0).
`default_nettype none
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time #(
   parameter int FRAC_BITS  = 28,
   parameter int ITER_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_c_real,
   input  logic signed [31:0] req_c_imag,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [33:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [15:0]        rsp_iterations,
   output logic               rsp_escaped,
   output logic [33:0]        rsp_magnitude_sq
);
   import mbe_pkg::*;

   mbe_cmd_type    cmd;
   mbe_status_type status;

   mbe_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mbe_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .ITER_WIDTH (ITER_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_iterations   (rsp_iterations),
      .rsp_escaped      (rsp_escaped),
      .rsp_magnitude_sq (rsp_magnitude_sq)
   );

   `MBE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `MBE_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy)
   `MBE_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `MBE_ASSERT_NEXT(a_done_strobe, clock, reset, cmd.done, rsp_valid)

endmodule

`default_nettype wire

// ===== bench/tb_mandelbrot_escape_time.sv =====
// Self-checking bench for the escape-time engine: directed corners, then random points
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time;

   import mbe_pkg::*;

   localparam int              FRAC           = 28;
   localparam longint          Z_MAX          = 64'sd34359738367;
   localparam logic [63:0]     SQ_MAX         = 64'h0000_000F_FFFF_FFFF;
   localparam logic [33:0]     BAIL_4         = 34'h0_4000_0000;
   localparam int              SETTLE_CYCLES  = 4;
   localparam int              WATCHDOG_LIMIT = 16384;

   typedef struct packed {
      logic [15:0] iterations;
      logic        escaped;
      logic [33:0] magnitude_sq;
   } escape_type;

   typedef struct packed {
      logic [15:0]        max_it;
      logic [33:0]        bailout;
      logic signed [31:0] cr;
      logic signed [31:0] ci;
      logic               pinned;
      escape_type         want;
   } probe_type;

   typedef enum {PICK_NEAR_SET, PICK_ANY, PICK_OUTSIDE, PICK_MIXED} pick_kind_type;

   localparam escape_type NO_WANT = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_c_real = '0;
   logic signed [31:0] req_c_imag = '0;
   logic               csr_we = 1'b0;
   mbe_csr_type        csr_index = CSR_MAX_ITERATIONS;
   logic [33:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic [15:0]        rsp_iterations;
   logic               rsp_escaped;
   logic [33:0]        rsp_magnitude_sq;

   logic [15:0] cfg_max_iter = MAX_IT_RESET;
   logic [33:0] cfg_bailout  = BAIL_4;

   escape_type expected_escapes[$];
   probe_type  probes[$];
   int      mismatches     = 0;
   int      results_seen   = 0;
   int      escaped_seen   = 0;
   int      bounded_seen   = 0;
   int      ceiling_seen   = 0;
   int      settings_used  = 1;
   int      stall_cycles   = 0;

   mandelbrot_escape_time dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_iterations   (rsp_iterations),
      .rsp_escaped      (rsp_escaped),
      .rsp_magnitude_sq (rsp_magnitude_sq)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b} + (128'd1 << (FRAC - 1));
      if (wide[127:FRAC+64] != '0)
         return '1;
      return wide[FRAC+63:FRAC];
   endfunction

   function automatic longint clamp_z(longint v);
      if (v > Z_MAX)
         return Z_MAX;
      if (v < -Z_MAX - 1)
         return -Z_MAX - 1;
      return v;
   endfunction

   function automatic logic [63:0] magnitude_of(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      return 64'(m);
   endfunction

   function automatic logic [63:0] square_sat(longint v);
      logic [63:0] s;
      s = scaled_product(magnitude_of(v), magnitude_of(v));
      return (s > SQ_MAX) ? SQ_MAX : s;
   endfunction

   function automatic escape_type predict_escape(logic signed [31:0] cr,
                                                 logic signed [31:0] ci);
      longint      zr, zi, sp;
      logic [63:0] zr_sq, zi_sq, p, sum;
      int unsigned count;
      logic        neg;
      escape_type  res;
      zr = 0;
      zi = 0;
      zr_sq = '0;
      zi_sq = '0;
      count = 0;
      while (zr_sq + zi_sq <= {30'd0, cfg_bailout} && count < cfg_max_iter) begin
         neg = (zr < 0) != (zi < 0);
         p = scaled_product(magnitude_of(zr) << 1, magnitude_of(zi));
         if (p > 64'(Z_MAX) + 64'd1)
            p = 64'(Z_MAX) + 64'd1;
         if (neg)
            sp = -longint'(p);
         else
            sp = (p > 64'(Z_MAX)) ? Z_MAX : longint'(p);
         zi = clamp_z(sp + longint'(ci));
         zr = clamp_z(longint'(zr_sq) - longint'(zi_sq) + longint'(cr));
         zr_sq = square_sat(zr);
         zi_sq = square_sat(zi);
         count++;
      end
      sum = zr_sq + zi_sq;
      res.iterations   = count[15:0];
      res.escaped      = count < cfg_max_iter;
      res.magnitude_sq = (sum > {30'd0, MAG_MAX}) ? MAG_MAX : sum[33:0];
      return res;
   endfunction

   function automatic void add_probe(logic [15:0] max_it, logic [33:0] bailout,
                                     logic signed [31:0] cr, logic signed [31:0] ci,
                                     logic pinned, escape_type want);
      probe_type row;
      row = '{max_it, bailout, cr, ci, pinned, want};
      probes.insert(probes.size(), row);
   endfunction

   task automatic pick_point(input pick_kind_type kind, output logic signed [31:0] cr,
                             output logic signed [31:0] ci);
      logic signed [31:0] big, other;
      pick_kind_type      k;
      k = kind;
      if (k == PICK_MIXED)
         k = ($urandom_range(0, 4) == 0) ? PICK_ANY : PICK_NEAR_SET;
      case (k)
         PICK_NEAR_SET: begin
            cr = $signed($urandom_range(0, 32'd671088640)) - 32'sd536870912;
            ci = $signed($urandom_range(0, 32'd644245094)) - 32'sd322122547;
         end
         PICK_OUTSIDE: begin
            big   = $signed($urandom_range(32'h2800_0000, 32'h7FFF_FFFF));
            other = $signed($urandom());
            if ($urandom_range(0, 1))
               big = -big;
            if ($urandom_range(0, 1)) begin
               cr = big;
               ci = other;
            end else begin
               cr = other;
               ci = big;
            end
         end
         default: begin
            cr = $signed($urandom());
            ci = $signed($urandom());
         end
      endcase
   endtask

   task automatic push_point(logic signed [31:0] cr, logic signed [31:0] ci, logic pinned,
                             escape_type want);
      req_c_real <= cr;
      req_c_imag <= ci;
      start      <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_escapes.insert(expected_escapes.size(),
                              pinned ? want : predict_escape(cr, ci));
   endtask

   task automatic drain_escapes();
      start <= 1'b0;
      while (expected_escapes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_escape_limits(logic [15:0] max_it, logic [33:0] bail);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_ITERATIONS;
      csr_wdata <= {18'd0, max_it};
      @(posedge clock);
      csr_index <= CSR_BAILOUT_SQ;
      csr_wdata <= bail;
      @(posedge clock);
      csr_we       <= 1'b0;
      cfg_max_iter = max_it;
      cfg_bailout  = bail;
      settings_used++;
   endtask

   task automatic run_escape_phase(int points, logic [15:0] max_it, logic [33:0] bail,
                                   int idle_pct, pick_kind_type kind);
      logic signed [31:0] cr, ci;
      drain_escapes();
      set_escape_limits(max_it, bail);
      for (int n = 0; n < points; n++) begin
         pick_point(kind, cr, ci);
         push_point(cr, ci, 1'b0, NO_WANT);
         if ($urandom_range(0, 63) == 0) begin
            drain_escapes();
         end else if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      escape_type want;
      if (!reset && rsp_valid) begin
         if (expected_escapes.size() == 0) begin
            $error("result with no point outstanding");
            mismatches++;
         end else begin
            want = expected_escapes.pop_front();
            if (rsp_iterations !== want.iterations) begin
               $error("iterations: expected %0d, got %0d", want.iterations, rsp_iterations);
               mismatches++;
            end
            if (rsp_escaped !== want.escaped) begin
               $error("escaped: expected %0d, got %0d", want.escaped, rsp_escaped);
               mismatches++;
            end
            if (rsp_magnitude_sq !== want.magnitude_sq) begin
               $error("magnitude_sq: expected 0x%09h, got 0x%09h",
                      want.magnitude_sq, rsp_magnitude_sq);
               mismatches++;
            end
            results_seen++;
            if (want.escaped)
               escaped_seen++;
            else
               bounded_seen++;
            if (want.magnitude_sq == MAG_MAX)
               ceiling_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      add_probe(16'd256, BAIL_4, 32'sh0000_0000, 32'sh0000_0000, 1'b1,
                '{16'd256, 1'b0, 34'd0});
      add_probe(16'd256, BAIL_4, 32'shE000_0000, 32'sh0000_0000, 1'b1,
                '{16'd256, 1'b0, BAIL_4});
      add_probe(16'd256, BAIL_4, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
                '{16'd1, 1'b1, MAG_MAX});
      add_probe(16'd256, BAIL_4, 32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh0400_0000, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'shF400_0000, 32'sh0199_999A, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh1000_0000, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh0000_0000, 32'sh1000_0000, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'shF000_0000, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, NO_WANT);
      add_probe(16'd256, BAIL_4, 32'sh4000_0000, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'd0, BAIL_4, 32'sh1000_0000, 32'sh1000_0000, 1'b1,
                '{16'd0, 1'b0, 34'd0});
      add_probe(16'd0, BAIL_4, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
                '{16'd0, 1'b0, 34'd0});
      add_probe(16'd1, BAIL_4, 32'sh0000_0000, 32'sh0000_0000, 1'b1,
                '{16'd1, 1'b0, 34'd0});
      add_probe(16'd1, BAIL_4, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
                '{16'd1, 1'b0, MAG_MAX});
      add_probe(16'd20, 34'd0, 32'sh0000_0000, 32'sh0000_0000, 1'b1,
                '{16'd20, 1'b0, 34'd0});
      add_probe(16'd20, 34'd0, 32'sh0000_0001, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'd20, 34'd0, 32'sh1000_0000, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'hFFFF, MAG_MAX, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
                '{16'd1, 1'b1, MAG_MAX});
      add_probe(16'hFFFF, MAG_MAX, 32'sh7E66_6666, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'hFFFF, MAG_MAX, 32'sh3000_0000, 32'sh0000_0000, 1'b0, NO_WANT);
      add_probe(16'hFFFF, MAG_MAX, 32'sh8800_0000, 32'sh7800_0000, 1'b0, NO_WANT);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) begin
         if (probes[i].max_it != cfg_max_iter || probes[i].bailout != cfg_bailout) begin
            drain_escapes();
            set_escape_limits(probes[i].max_it, probes[i].bailout);
         end
         push_point(probes[i].cr, probes[i].ci, probes[i].pinned, probes[i].want);
      end

      run_escape_phase(240, MAX_IT_RESET, BAIL_4, 0, PICK_MIXED);
      run_escape_phase(280, 16'd40, BAIL_4, 49, PICK_MIXED);
      run_escape_phase(100, 16'd20, 34'd0, 0, PICK_MIXED);
      run_escape_phase(150, 16'hFFFF, MAG_MAX, 28, PICK_OUTSIDE);
      run_escape_phase(130, 16'd1, {2'($urandom_range(0, 3)), $urandom()}, 49, PICK_ANY);
      repeat (5)
         run_escape_phase(50, 16'($urandom_range(2, 48)), {2'b00, $urandom()}, 28,
                          PICK_MIXED);

      drain_escapes();
      repeat (16) @(posedge clock);

      $display("%0d points checked across %0d limit settings, corners and zero limit first",
               results_seen, settings_used);
      $display("%0d escaped, %0d stayed bounded, %0d at the magnitude ceiling",
               escaped_seen, bounded_seen, ceiling_seen);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
